// File: hdl/fcs_pkg.sv
// ----------------------------------------------------------------------------
// Flash command sequencer package
// Shared types, command codes, register indexes and lane helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcs_pkg;

    // Flash command bytes, one per chip lane.
    localparam logic [7:0] CMD_CLEAR   = 8'h50;
    localparam logic [7:0] CMD_PROGRAM = 8'h40;
    localparam logic [7:0] CMD_ERASE   = 8'h20;
    localparam logic [7:0] CMD_UNLOCK  = 8'h60;
    localparam logic [7:0] CMD_CONFIRM = 8'hD0;
    localparam logic [7:0] CMD_RESET   = 8'hFF;

    // Status register bits, one per chip lane.
    localparam logic [7:0] STS_READY      = 8'h80;
    localparam logic [7:0] STS_ERR_PROG   = 8'h1A;
    localparam logic [7:0] STS_ERR_ERASE  = 8'h2A;
    localparam logic [7:0] STS_ERR_UNLOCK = 8'h38;

    // Item kinds and operations. The reserved operation code has no meaning
    // and a start that carries it is dropped.
    localparam logic       KIND_START  = 1'b0;
    localparam logic       KIND_REPLY  = 1'b1;
    localparam logic [1:0] OP_PROGRAM  = 2'd0;
    localparam logic [1:0] OP_ERASE    = 2'd1;
    localparam logic [1:0] OP_UNLOCK   = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    // Bus access sizes.
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;

    // Configuration register indexes.
    localparam logic [1:0] REG_ACCESS_SIZE   = 2'd0;
    localparam logic [1:0] REG_CHIPS_LOG2    = 2'd1;
    localparam logic [1:0] REG_POLL_LIMIT    = 2'd2;
    localparam logic [1:0] REG_PROGRAM_OPCODE = 2'd3;

    // Configuration reset values.
    localparam logic [1:0]  RST_ACCESS_SIZE    = 2'd2;
    localparam logic [1:0]  RST_CHIPS_LOG2     = 2'd0;
    localparam logic [15:0] RST_POLL_LIMIT     = 16'd1000;
    localparam logic [7:0]  RST_PROGRAM_OPCODE = CMD_PROGRAM;

    localparam int unsigned BURST_MAX = 4;

    typedef struct packed {
        logic [1:0]  access_size;
        logic [1:0]  chips_log2;
        logic [15:0] poll_limit;
        logic [7:0]  program_opcode;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  operation;
        logic [31:0] base_addr;
        logic [31:0] target_addr;
        logic [31:0] write_value;
        logic        wait_done;
        logic [31:0] read_value;
    } item_t;

    typedef struct packed {
        logic        bus_read;
        logic [31:0] bus_addr;
        logic [31:0] bus_data;
        logic        done_res;
        logic        failed;
        logic        last;
    } result_t;

    typedef struct packed {
        logic        polling;
        logic [15:0] polls_left;
        logic [1:0]  current_op;
        logic [31:0] saved_base;
    } seq_state_t;

    // Log2 of the bus width in bytes; the unused size code counts as word.
    function automatic logic [1:0] width_log2(logic [1:0] size);
        logic [1:0] wl;
        case (size)
            SIZE_BYTE: wl = 2'd0;
            SIZE_HALF: wl = 2'd1;
            default:   wl = 2'd2;
        endcase
        return wl;
    endfunction

    function automatic logic [31:0] width_mask(logic [1:0] size);
        logic [31:0] m;
        case (width_log2(size))
            2'd0:    m = 32'h0000_00FF;
            2'd1:    m = 32'h0000_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // Replicate a command byte into the low byte of every chip lane.
    function automatic logic [31:0] spread(logic [1:0] size, logic [1:0] chips_log2,
                                           logic [7:0] cmd);
        logic [1:0]  wl;
        logic [1:0]  cl;
        logic [31:0] v;
        wl = width_log2(size);
        cl = (chips_log2 > wl) ? wl : chips_log2;
        v  = {24'd0, cmd};
        case ({wl, cl})
            {2'd1, 2'd1}: v = {16'd0, cmd, cmd};
            {2'd2, 2'd1}: v = {8'd0, cmd, 8'd0, cmd};
            {2'd2, 2'd2}: v = {cmd, cmd, cmd, cmd};
            default:      v = {24'd0, cmd};
        endcase
        return v;
    endfunction

endpackage

// File: hdl/fcs_if.sv
// ----------------------------------------------------------------------------
// Flash command sequencer channels
// Valid/ready channels for incoming items and outgoing bus accesses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fcs_item_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [1:0]  operation;
    logic [31:0] base_addr;
    logic [31:0] target_addr;
    logic [31:0] write_value;
    logic        wait_done;
    logic [31:0] read_value;

    modport source (
        output valid, kind, operation, base_addr, target_addr, write_value,
               wait_done, read_value,
        input  ready
    );
    modport sink (
        input  valid, kind, operation, base_addr, target_addr, write_value,
               wait_done, read_value,
        output ready
    );
endinterface

interface fcs_result_if;
    logic        valid;
    logic        ready;
    logic        bus_read;
    logic [31:0] bus_addr;
    logic [31:0] bus_data;
    logic        done_res;
    logic        failed;
    logic        last;

    modport source (
        output valid, bus_read, bus_addr, bus_data, done_res, failed, last,
        input  ready
    );
    modport sink (
        input  valid, bus_read, bus_addr, bus_data, done_res, failed, last,
        output ready
    );
endinterface

// File: hdl/flash_command_sequencer.sv
// ----------------------------------------------------------------------------
// Flash command sequencer
// Bus-master sequencer for program, sector erase and sector unlock commands.
// ----------------------------------------------------------------------------
// Channel   Direction  Transfer
// item      in         start of an operation, or the reply to a status read
// result    out        one bus access request (write or status read)
// APB       in         configuration registers at byte addresses 0, 4, 8, 12
//
// A start item yields four result transfers and a status reply yields one; the
// single result port drains them from the four-entry burst buffer in turn, and
// no new item is taken while more than one of them is still waiting. Ignored
// items yield nothing. Reset returns the configuration registers to their
// defaults and the sequencer to idle. A stall on the result side holds the
// burst buffer; the next item is taken in the same cycle the last buffered
// result transfers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flash_command_sequencer #(
    parameter int ADDR_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,

    fcs_item_if.sink            item,
    fcs_result_if.source        result
);

    // Configuration registers.
    fcs_pkg::cfg_t       cfg_reg;
    fcs_pkg::cfg_t       cfg_next;
    logic                cfg_write;

    // Sequencer state.
    fcs_pkg::seq_state_t state_reg;
    fcs_pkg::seq_state_t state_next;

    // Burst buffer: results waiting to go out, head at entry zero.
    fcs_pkg::result_t    burst_reg  [fcs_pkg::BURST_MAX];
    fcs_pkg::result_t    burst_next [fcs_pkg::BURST_MAX];
    logic [2:0]          cnt_reg;
    logic [2:0]          cnt_next;

    // Step logic outputs.
    fcs_pkg::item_t      in_item;
    fcs_pkg::result_t    step_results [fcs_pkg::BURST_MAX];
    logic [2:0]          step_count;
    fcs_pkg::seq_state_t step_state;

    logic                in_xfer;
    logic                out_xfer;

    // ------------------------------------------------------------------
    // APB configuration port. Writes land on the access phase; reads are
    // served combinationally since pready is tied high.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (paddr[3:2])
                fcs_pkg::REG_ACCESS_SIZE:    cfg_next.access_size    = pwdata[1:0];
                fcs_pkg::REG_CHIPS_LOG2:     cfg_next.chips_log2     = pwdata[1:0];
                fcs_pkg::REG_POLL_LIMIT:     cfg_next.poll_limit     = pwdata[15:0];
                fcs_pkg::REG_PROGRAM_OPCODE: cfg_next.program_opcode = pwdata[7:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            fcs_pkg::REG_ACCESS_SIZE:    prdata = {30'd0, cfg_reg.access_size};
            fcs_pkg::REG_CHIPS_LOG2:     prdata = {30'd0, cfg_reg.chips_log2};
            fcs_pkg::REG_POLL_LIMIT:     prdata = {16'd0, cfg_reg.poll_limit};
            fcs_pkg::REG_PROGRAM_OPCODE: prdata = {24'd0, cfg_reg.program_opcode};
            default:                     prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Item intake. A new item is taken when the buffer is empty, or when
    // its only remaining entry transfers in this cycle.
    // ------------------------------------------------------------------
    assign out_xfer   = result.valid && result.ready;
    assign item.ready = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && result.ready);
    assign in_xfer    = item.valid && item.ready;

    assign in_item.kind        = item.kind;
    assign in_item.operation   = item.operation;
    assign in_item.base_addr   = item.base_addr;
    assign in_item.target_addr = item.target_addr;
    assign in_item.write_value = item.write_value;
    assign in_item.wait_done   = item.wait_done;
    assign in_item.read_value  = item.read_value;

    fcs_step #(
        .ADDR_BITS (ADDR_BITS)
    ) u_step (
        .cfg        (cfg_reg),
        .item       (in_item),
        .state      (state_reg),
        .results    (step_results),
        .count      (step_count),
        .state_next (step_state)
    );

    // The whole burst for an item is formed in one pass and loaded at once;
    // afterwards the buffer shifts toward the head on each result transfer.
    always_comb
    begin
        burst_next = burst_reg;
        cnt_next   = cnt_reg;
        state_next = state_reg;
        if (in_xfer)
        begin
            burst_next = step_results;
            cnt_next   = step_count;
            state_next = step_state;
        end
        else if (out_xfer)
        begin
            for (int i = 0; i < fcs_pkg::BURST_MAX - 1; i++)
            begin
                burst_next[i] = burst_reg[i + 1];
            end
            cnt_next = cnt_reg - 3'd1;
        end
    end

    // ------------------------------------------------------------------
    // Result channel driven from the head of the buffer.
    // ------------------------------------------------------------------
    assign result.valid    = (cnt_reg != 3'd0);
    assign result.bus_read = burst_reg[0].bus_read;
    assign result.bus_addr = burst_reg[0].bus_addr;
    assign result.bus_data = burst_reg[0].bus_data;
    assign result.done_res = burst_reg[0].done_res;
    assign result.failed   = burst_reg[0].failed;
    assign result.last     = burst_reg[0].last;

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.access_size    <= fcs_pkg::RST_ACCESS_SIZE;
            cfg_reg.chips_log2     <= fcs_pkg::RST_CHIPS_LOG2;
            cfg_reg.poll_limit     <= fcs_pkg::RST_POLL_LIMIT;
            cfg_reg.program_opcode <= fcs_pkg::RST_PROGRAM_OPCODE;
            state_reg.polling      <= 1'b0;
            state_reg.polls_left   <= 16'd0;
            state_reg.current_op   <= fcs_pkg::OP_PROGRAM;
            state_reg.saved_base   <= 32'd0;
            cnt_reg                <= 3'd0;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Buffer payload needs no reset; cnt_reg qualifies it.
    always_ff @(posedge clk)
    begin
        burst_reg <= burst_next;
    end

endmodule

// File: hdl/fcs_step.sv
// ----------------------------------------------------------------------------
// Flash command sequencer step logic
// Forms the bus accesses and next sequencer state for one accepted item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcs_step #(
    parameter int ADDR_BITS = 32
) (
    input  fcs_pkg::cfg_t       cfg,
    input  fcs_pkg::item_t      item,
    input  fcs_pkg::seq_state_t state,
    output fcs_pkg::result_t    results [fcs_pkg::BURST_MAX],
    output logic [2:0]          count,
    output fcs_pkg::seq_state_t state_next
);

    localparam logic [31:0] ADDR_MASK = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF :
                                        32'((64'd1 << ADDR_BITS) - 64'd1);

    logic [31:0] wmask;
    logic [31:0] status;
    logic [31:0] base_m;
    logic [31:0] target_m;
    logic [7:0]  setup_cmd;
    logic [31:0] third_data;
    logic [7:0]  err_byte;
    logic        ready_hit;
    logic        err_hit;
    logic [15:0] polls_dec;
    logic [31:0] reset_data;

    function automatic fcs_pkg::result_t mk(logic rd, logic [31:0] addr, logic [31:0] data,
                                             logic done, logic fail, logic lst);
        fcs_pkg::result_t r;
        r.bus_read = rd;
        r.bus_addr = addr;
        r.bus_data = rd ? 32'd0 : data;
        r.done_res = done;
        r.failed   = fail;
        r.last     = lst;
        return r;
    endfunction

    always_comb
    begin
        wmask      = fcs_pkg::width_mask(cfg.access_size);
        status     = item.read_value & wmask;
        base_m     = item.base_addr & ADDR_MASK;
        target_m   = item.target_addr & ADDR_MASK;
        reset_data = fcs_pkg::spread(cfg.access_size, cfg.chips_log2, fcs_pkg::CMD_RESET);

        case (item.operation)
            fcs_pkg::OP_PROGRAM: setup_cmd = cfg.program_opcode;
            fcs_pkg::OP_ERASE:   setup_cmd = fcs_pkg::CMD_ERASE;
            default:             setup_cmd = fcs_pkg::CMD_UNLOCK;
        endcase
        if (item.operation == fcs_pkg::OP_PROGRAM)
        begin
            third_data = item.write_value & wmask;
        end
        else
        begin
            third_data = fcs_pkg::spread(cfg.access_size, cfg.chips_log2,
                                         fcs_pkg::CMD_CONFIRM);
        end

        case (state.current_op)
            fcs_pkg::OP_PROGRAM: err_byte = fcs_pkg::STS_ERR_PROG;
            fcs_pkg::OP_ERASE:   err_byte = fcs_pkg::STS_ERR_ERASE;
            default:             err_byte = fcs_pkg::STS_ERR_UNLOCK;
        endcase
        ready_hit = (status & fcs_pkg::spread(cfg.access_size, cfg.chips_log2,
                                              fcs_pkg::STS_READY)) != 32'd0;
        err_hit   = (status & fcs_pkg::spread(cfg.access_size, cfg.chips_log2,
                                              err_byte)) != 32'd0;
        polls_dec = state.polls_left - 16'd1;

        for (int i = 0; i < fcs_pkg::BURST_MAX; i++)
        begin
            results[i] = mk(1'b0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);
        end
        count      = 3'd0;
        state_next = state;

        if (item.kind == fcs_pkg::KIND_START)
        begin
            if (!state.polling && item.operation != fcs_pkg::OP_RESERVED)
            begin
                results[0] = mk(1'b0, base_m,
                                fcs_pkg::spread(cfg.access_size, cfg.chips_log2,
                                                fcs_pkg::CMD_CLEAR),
                                1'b0, 1'b0, 1'b0);
                results[1] = mk(1'b0, target_m,
                                fcs_pkg::spread(cfg.access_size, cfg.chips_log2, setup_cmd),
                                1'b0, 1'b0, 1'b0);
                results[2] = mk(1'b0, target_m, third_data, 1'b0, 1'b0, 1'b0);
                count      = 3'd4;
                if (item.operation == fcs_pkg::OP_PROGRAM && !item.wait_done)
                begin
                    // Program without waiting: finish straight away.
                    results[3] = mk(1'b0, base_m, reset_data, 1'b1, 1'b0, 1'b1);
                end
                else
                begin
                    results[3]            = mk(1'b1, base_m, 32'd0, 1'b0, 1'b0, 1'b1);
                    state_next.polling    = 1'b1;
                    state_next.current_op = item.operation;
                    state_next.saved_base = base_m;
                    state_next.polls_left = (cfg.poll_limit != 16'd0) ? cfg.poll_limit
                                                                     : 16'd1;
                end
            end
        end
        else if (state.polling)
        begin
            count = 3'd1;
            if (ready_hit)
            begin
                results[0]         = mk(1'b0, state.saved_base, reset_data,
                                        1'b1, err_hit, 1'b1);
                state_next.polling = 1'b0;
            end
            else
            begin
                state_next.polls_left = polls_dec;
                if (polls_dec == 16'd0)
                begin
                    // Poll budget used up: finish with a timeout error.
                    results[0]         = mk(1'b0, state.saved_base, reset_data,
                                            1'b1, 1'b1, 1'b1);
                    state_next.polling = 1'b0;
                end
                else
                begin
                    results[0] = mk(1'b1, state.saved_base, 32'd0, 1'b0, 1'b0, 1'b1);
                end
            end
        end
    end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Flash command sequencer testbench
// Drives start and status-reply items into the sequencer and checks every bus
// access that it requests against a cycle-free model of the command flow.
// Registers are set over APB between phases, with directed cases first and
// random command sequences after.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import fcs_pkg::*;

    localparam logic [1:0] SIZE_WORD     = 2'd2;
    // The unused size code, which the sequencer treats as a word access.
    localparam logic [1:0] SIZE_WORD_ALT = 2'd3;

    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES   = 150;
    localparam int unsigned PHASE_ITEMS   = 14;
    localparam int unsigned RANDOM_ROUNDS = 5;
    localparam int unsigned CALM_ITEMS    = 25;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fcs_item_if   item_ch();
    fcs_result_if access_ch();

    flash_command_sequencer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_ch),
        .result  (access_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the registers and of the polling state.
    cfg_t        shadow_cfg;
    seq_state_t  shadow_seq;

    // Items waiting to be offered, and bus accesses the sequencer still owes.
    item_t       item_backlog[$];
    result_t     due_accesses[$];

    item_t       on_wire;
    int unsigned mismatches = 0;
    int unsigned feed_gap;
    int unsigned feed_calm;
    int unsigned drain_gap;
    int unsigned drain_calm;
    logic        got_valid;
    result_t     got;
    logic        hold_off = 1'b0;
    logic        squeeze_armed = 1'b0;

    // ------------------------------------------------------------------------
    // Command flow model
    // ------------------------------------------------------------------------

    function automatic int unsigned bus_bits();
        case (shadow_cfg.access_size)
            SIZE_BYTE: return 8;
            SIZE_HALF: return 16;
            default:   return 32;
        endcase
    endfunction

    function automatic logic [31:0] width_cut(logic [31:0] v);
        if (bus_bits() == 32)
            return v;
        return v & ((32'd1 << bus_bits()) - 32'd1);
    endfunction

    // Copy a command byte into the low byte of each chip lane. The chip count
    // is capped so that no lane is narrower than one byte.
    function automatic logic [31:0] lane_fill(logic [7:0] cmd);
        int unsigned width;
        int unsigned chips;
        logic [31:0] fill;
        width = bus_bits();
        chips = 32'd1 << shadow_cfg.chips_log2;
        if (chips > width / 8)
            chips = width / 8;
        fill = '0;
        for (int unsigned i = 0; i < chips; i++)
            fill |= {24'd0, cmd} << (i * (width / chips));
        return fill;
    endfunction

    function automatic logic [7:0] err_bits(logic [1:0] op);
        case (op)
            OP_PROGRAM: return STS_ERR_PROG;
            OP_ERASE:   return STS_ERR_ERASE;
            default:    return STS_ERR_UNLOCK;
        endcase
    endfunction

    function automatic void owe_access(logic rd, logic [31:0] addr, logic [31:0] data,
                                       logic done, logic fail, logic last);
        result_t r;
        r.bus_read = rd;
        r.bus_addr = addr;
        r.bus_data = rd ? 32'd0 : data;
        r.done_res = done;
        r.failed   = fail;
        r.last     = last;
        due_accesses.push_back(r);
    endfunction

    // Works out the bus accesses that one accepted item causes and advances
    // the shadow polling state.
    function automatic void plan_bus_accesses(item_t it);
        logic [31:0] status;
        logic [7:0]  setup;
        logic [31:0] third;
        logic        bad;
        status = width_cut(it.read_value);
        if (it.kind == KIND_START)
        begin
            // A start is dropped while an operation is still polling, or when it carries the reserved code.
            if (shadow_seq.polling || it.operation == OP_RESERVED)
                return;
            if (it.operation == OP_PROGRAM)
            begin
                setup = shadow_cfg.program_opcode;
                third = width_cut(it.write_value);
            end
            else
            begin
                setup = (it.operation == OP_ERASE) ? CMD_ERASE : CMD_UNLOCK;
                third = lane_fill(CMD_CONFIRM);
            end
            owe_access(1'b0, it.base_addr, lane_fill(CMD_CLEAR), 1'b0, 1'b0, 1'b0);
            owe_access(1'b0, it.target_addr, lane_fill(setup), 1'b0, 1'b0, 1'b0);
            owe_access(1'b0, it.target_addr, third, 1'b0, 1'b0, 1'b0);
            if (it.operation == OP_PROGRAM && !it.wait_done)
            begin
                owe_access(1'b0, it.base_addr, lane_fill(CMD_RESET), 1'b1, 1'b0, 1'b1);
                return;
            end
            owe_access(1'b1, it.base_addr, 32'd0, 1'b0, 1'b0, 1'b1);
            shadow_seq.polling    = 1'b1;
            shadow_seq.current_op = it.operation;
            shadow_seq.saved_base = it.base_addr;
            shadow_seq.polls_left = (shadow_cfg.poll_limit == 16'd0)
                                    ? 16'd1 : shadow_cfg.poll_limit;
            return;
        end
        // A reply with nothing polling is dropped.
        if (!shadow_seq.polling)
            return;
        if ((status & lane_fill(STS_READY)) != 32'd0)
        begin
            bad = (status & lane_fill(err_bits(shadow_seq.current_op))) != 32'd0;
            owe_access(1'b0, shadow_seq.saved_base, lane_fill(CMD_RESET), 1'b1, bad, 1'b1);
            shadow_seq.polling = 1'b0;
            return;
        end
        shadow_seq.polls_left = shadow_seq.polls_left - 16'd1;
        if (shadow_seq.polls_left == 16'd0)
        begin
            // Out of polls: finish with a reset write flagged as failed.
            owe_access(1'b0, shadow_seq.saved_base, lane_fill(CMD_RESET), 1'b1, 1'b1, 1'b1);
            shadow_seq.polling = 1'b0;
        end
        else
            owe_access(1'b1, shadow_seq.saved_base, 32'd0, 1'b0, 1'b0, 1'b1);
    endfunction

    // ------------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------------

    function automatic item_t start_item(logic [1:0] op, logic [31:0] base,
                                         logic [31:0] target, logic [31:0] data,
                                         logic poll);
        item_t it;
        it.kind        = KIND_START;
        it.operation   = op;
        it.base_addr   = base;
        it.target_addr = target;
        it.write_value = data;
        it.wait_done   = poll;
        it.read_value  = $urandom;
        return it;
    endfunction

    // The fields that a reply does not use carry random values.
    function automatic item_t reply_item(logic [31:0] status);
        item_t it;
        it.kind        = KIND_REPLY;
        it.operation   = 2'($urandom_range(0, 3));
        it.base_addr   = $urandom;
        it.target_addr = $urandom;
        it.write_value = $urandom;
        it.wait_done   = 1'($urandom_range(0, 1));
        it.read_value  = status;
        return it;
    endfunction

    // A status with no ready bit in any lane; bits above the bus width stay
    // random, since the sequencer must ignore them.
    function automatic logic [31:0] busy_status();
        return $urandom & ~lane_fill(STS_READY);
    endfunction

    // A status with the ready bit in at least one lane, and with the error
    // bits of the operation either random or all clear.
    function automatic logic [31:0] ready_status(logic [1:0] op);
        logic [31:0] v;
        logic [31:0] ready_bits;
        logic [31:0] pick;
        v = $urandom;
        if ($urandom_range(0, 1) != 0)
            v &= ~lane_fill(err_bits(op));
        ready_bits = lane_fill(STS_READY);
        pick = ready_bits & $urandom;
        if (pick == 32'd0)
            pick = ready_bits;
        return v | pick;
    endfunction

    function automatic int unsigned draw_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------------
    // Item driver: offers the backlog with random gaps. A run of items with
    // no gaps starts now and then, so back-to-back transfers occur as well.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            feed_gap      <= 0;
            feed_calm     <= 0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
                plan_bus_accesses(on_wire);
            if (!item_ch.valid || item_ch.ready)
            begin
                if (feed_gap != 0)
                begin
                    item_ch.valid <= 1'b0;
                    feed_gap      <= feed_gap - 1;
                end
                else if (item_backlog.size() != 0)
                begin
                    on_wire = item_backlog.pop_front();
                    item_ch.valid       <= 1'b1;
                    item_ch.kind        <= on_wire.kind;
                    item_ch.operation   <= on_wire.operation;
                    item_ch.base_addr   <= on_wire.base_addr;
                    item_ch.target_addr <= on_wire.target_addr;
                    item_ch.write_value <= on_wire.write_value;
                    item_ch.wait_done   <= on_wire.wait_done;
                    item_ch.read_value  <= on_wire.read_value;
                    if (feed_calm != 0)
                    begin
                        feed_calm <= feed_calm - 1;
                        feed_gap  <= 0;
                    end
                    else
                    begin
                        if ($urandom_range(0, 15) == 0)
                            feed_calm <= CALM_ITEMS;
                        feed_gap <= draw_gap();
                    end
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Access monitor: stalls the result side at random and checks each
    // transfer in the cycle after it happens, so that the expectation for an
    // item accepted at the same edge is always in place.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            access_ch.ready <= 1'b0;
            drain_gap       <= 0;
            drain_calm      <= 0;
            got_valid       <= 1'b0;
        end
        else
        begin
            if (got_valid)
            begin
                if (due_accesses.size() == 0)
                begin
                    $error("unexpected bus access: addr %h data %h read %b",
                           got.bus_addr, got.bus_data, got.bus_read);
                    mismatches++;
                end
                else
                begin
                    want = due_accesses.pop_front();
                    if (got.bus_read !== want.bus_read)
                    begin
                        $error("bus_read: expected %b, actual %b", want.bus_read, got.bus_read);
                        mismatches++;
                    end
                    if (got.bus_addr !== want.bus_addr)
                    begin
                        $error("bus_addr: expected %h, actual %h", want.bus_addr, got.bus_addr);
                        mismatches++;
                    end
                    if (got.bus_data !== want.bus_data)
                    begin
                        $error("bus_data: expected %h, actual %h", want.bus_data, got.bus_data);
                        mismatches++;
                    end
                    if (got.done_res !== want.done_res)
                    begin
                        $error("done_res: expected %b, actual %b", want.done_res, got.done_res);
                        mismatches++;
                    end
                    if (got.failed !== want.failed)
                    begin
                        $error("failed: expected %b, actual %b", want.failed, got.failed);
                        mismatches++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last: expected %b, actual %b", want.last, got.last);
                        mismatches++;
                    end
                end
            end
            got_valid <= access_ch.valid && access_ch.ready;
            got       <= {access_ch.bus_read, access_ch.bus_addr, access_ch.bus_data,
                          access_ch.done_res, access_ch.failed, access_ch.last};
            if (hold_off)
                access_ch.ready <= 1'b0;
            else if (drain_gap != 0)
            begin
                access_ch.ready <= 1'b0;
                drain_gap       <= drain_gap - 1;
            end
            else
            begin
                access_ch.ready <= 1'b1;
                if (drain_calm != 0)
                    drain_calm <= drain_calm - 1;
                else
                begin
                    if ($urandom_range(0, 15) == 0)
                        drain_calm <= CALM_ITEMS;
                    drain_gap <= draw_gap();
                end
            end
        end
    end

    // Long hold-off on the result side while the driver keeps offering items,
    // so the burst buffer fills up and the item side is stalled.
    initial
    begin
        wait (squeeze_armed);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Register access and phase control
    // ------------------------------------------------------------------------

    // APB write followed by a read of the same register.
    task automatic set_reg(logic [1:0] idx, logic [31:0] value);
        logic [31:0] want;
        logic [31:0] seen;
        case (idx)
            REG_ACCESS_SIZE:
            begin
                shadow_cfg.access_size = value[1:0];
                want = {30'd0, value[1:0]};
            end
            REG_CHIPS_LOG2:
            begin
                shadow_cfg.chips_log2 = value[1:0];
                want = {30'd0, value[1:0]};
            end
            REG_POLL_LIMIT:
            begin
                shadow_cfg.poll_limit = value[15:0];
                want = {16'd0, value[15:0]};
            end
            default:
            begin
                shadow_cfg.program_opcode = value[7:0];
                want = {24'd0, value[7:0]};
            end
        endcase
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        // The write lands at this edge; psel stays high into the read setup.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        seen = prdata;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (seen !== want)
        begin
            $error("register %0d readback: expected %h, actual %h", idx, want, seen);
            mismatches++;
        end
    endtask

    // Waits until every item is taken and every owed access has arrived, then
    // lets a dropped item that may still be inside the sequencer clear out.
    task automatic settle();
        while (item_backlog.size() != 0 || item_ch.valid || due_accesses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly well-formed command sequences with random content: a start, a
    // few busy replies and a ready reply. Some sequences run out of polls,
    // some stop short, and a few items are pure noise.
    task automatic queue_random_phase();
        int unsigned queued;
        int unsigned polls;
        int unsigned limit;
        logic [1:0]  op;
        logic        poll;
        item_t       noise;
        queued = 0;
        limit = (shadow_cfg.poll_limit == 16'd0) ? 1 : shadow_cfg.poll_limit;
        while (queued < PHASE_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                noise.kind        = 1'($urandom_range(0, 1));
                noise.operation   = 2'($urandom_range(0, 3));
                noise.base_addr   = $urandom;
                noise.target_addr = $urandom;
                noise.write_value = $urandom;
                noise.wait_done   = 1'($urandom_range(0, 1));
                noise.read_value  = $urandom;
                item_backlog.push_back(noise);
                queued++;
            end
            else
            begin
                op   = 2'($urandom_range(0, 2));
                poll = 1'($urandom_range(0, 1));
                item_backlog.push_back(start_item(op, $urandom, $urandom, $urandom, poll));
                queued++;
                if (op != OP_PROGRAM || poll)
                begin
                    polls = (limit <= 4 && $urandom_range(0, 2) == 0)
                            ? limit : $urandom_range(0, 3);
                    repeat (polls)
                    begin
                        item_backlog.push_back(reply_item(busy_status()));
                        queued++;
                    end
                    if ($urandom_range(0, 7) != 0)
                    begin
                        item_backlog.push_back(reply_item(ready_status(op)));
                        queued++;
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        cfg_t c;
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        item_ch.valid       = 1'b0;
        item_ch.kind        = KIND_START;
        item_ch.operation   = OP_PROGRAM;
        item_ch.base_addr   = '0;
        item_ch.target_addr = '0;
        item_ch.write_value = '0;
        item_ch.wait_done   = 1'b0;
        item_ch.read_value  = '0;
        access_ch.ready     = 1'b0;
        shadow_cfg = '{RST_ACCESS_SIZE, RST_CHIPS_LOG2, RST_POLL_LIMIT, RST_PROGRAM_OPCODE};
        shadow_seq = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: word bus, one chip. A reply while idle is dropped,
        // then every operation with and without errors, a start during
        // polling and a start with the reserved operation code.
        item_backlog.push_back(reply_item(32'hFFFF_FFFF));
        item_backlog.push_back(start_item(OP_PROGRAM, 32'h0, 32'hFFFF_FFFF,
                                          32'hFFFF_FFFF, 1'b0));
        item_backlog.push_back(start_item(OP_PROGRAM, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1));
        item_backlog.push_back(reply_item(32'h0000_0000));
        item_backlog.push_back(reply_item(32'h0000_009A));
        item_backlog.push_back(start_item(OP_ERASE, $urandom, $urandom, $urandom, 1'b1));
        item_backlog.push_back(start_item(OP_UNLOCK, $urandom, $urandom, $urandom, 1'b1));
        item_backlog.push_back(reply_item(32'h0000_0080));
        item_backlog.push_back(start_item(OP_UNLOCK, $urandom, $urandom, $urandom, 1'b0));
        item_backlog.push_back(reply_item(32'h0000_00B8));
        item_backlog.push_back(start_item(OP_RESERVED, $urandom, $urandom, $urandom, 1'b1));
        item_backlog.push_back(start_item(OP_ERASE, $urandom, $urandom, $urandom, 1'b0));
        item_backlog.push_back(reply_item(32'h0000_0090));
        settle();

        // A poll limit of zero allows one status read; the reply that comes
        // after the timeout is dropped.
        set_reg(REG_POLL_LIMIT, 32'd0);
        item_backlog.push_back(start_item(OP_ERASE, $urandom, $urandom, $urandom, 1'b1));
        item_backlog.push_back(reply_item(32'h0000_007F));
        item_backlog.push_back(reply_item(32'h0000_0080));
        settle();

        // Byte bus with too many chips for its width, the alternate program
        // opcode, and status bits above the bus width that must be ignored.
        set_reg(REG_ACCESS_SIZE, {30'd0, SIZE_BYTE});
        set_reg(REG_CHIPS_LOG2, 32'd3);
        set_reg(REG_PROGRAM_OPCODE, 32'h10);
        set_reg(REG_POLL_LIMIT, 32'd2);
        item_backlog.push_back(start_item(OP_PROGRAM, $urandom, $urandom, 32'hFFFF_FFFF, 1'b1));
        item_backlog.push_back(reply_item(32'hFFFF_FF7F));
        item_backlog.push_back(reply_item(32'h0000_8000));
        item_backlog.push_back(start_item(OP_UNLOCK, $urandom, $urandom, $urandom, 1'b1));
        settle();

        // The unlock above is still polling: change the lane layout under it
        // and answer with the ready bit in the upper lane only.
        set_reg(REG_ACCESS_SIZE, {30'd0, SIZE_HALF});
        set_reg(REG_CHIPS_LOG2, 32'd1);
        item_backlog.push_back(reply_item(32'h0000_8000));
        settle();

        set_reg(REG_ACCESS_SIZE, {30'd0, SIZE_WORD_ALT});
        set_reg(REG_CHIPS_LOG2, 32'd2);
        item_backlog.push_back(start_item(OP_PROGRAM, $urandom, $urandom, $urandom, 1'b0));
        settle();

        // Random phases, each under its own settings; the first four cover
        // the extremes of every register.
        for (int unsigned round = 0; round < RANDOM_ROUNDS; round++)
        begin
            case (round)
                0: c = '{SIZE_WORD, 2'd2, 16'hFFFF, CMD_PROGRAM};
                1: c = '{SIZE_BYTE, 2'd0, 16'd1, 8'h10};
                2: c = '{SIZE_HALF, 2'd1, 16'd3, 8'hFF};
                3: c = '{SIZE_WORD_ALT, 2'd3, 16'($urandom_range(1, 6)), 8'h00};
                default: c = '{2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                               16'($urandom_range(0, 8)), 8'($urandom_range(0, 255))};
            endcase
            set_reg(REG_ACCESS_SIZE, {30'd0, c.access_size});
            set_reg(REG_CHIPS_LOG2, {30'd0, c.chips_log2});
            set_reg(REG_POLL_LIMIT, {16'd0, c.poll_limit});
            set_reg(REG_PROGRAM_OPCODE, {24'd0, c.program_opcode});
            queue_random_phase();
            if (round == 0)
                squeeze_armed = 1'b1;
            settle();
        end

        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
